### rtl/core/v2py_pkg.sv
// v2py_pkg: constants, the cordic angle table and the stage record of vector_to_pitch_yaw
// used by v2py_stage and vector_to_pitch_yaw; depends on nothing
package v2py_pkg;

  localparam int unsigned InW      = 32;
  localparam int unsigned OutW     = 25;
  localparam int unsigned GuardW   = 24;
  localparam int unsigned DpW      = 64;
  localparam int unsigned AccW     = 32;
  localparam int unsigned MaxSteps = 32;

  localparam logic signed [31:0] GainQ30  = 32'sd1768195363;
  localparam logic [OutW-1:0]    Deg90Q16  = 25'd5898240;
  localparam logic [OutW-1:0]    Deg270Q16 = 25'd17694720;
  localparam logic [OutW-1:0]    Deg360Q16 = 25'd23592960;

  typedef logic signed [DpW-1:0] dp_t;
  typedef logic [AccW-1:0]       acc_t;

  // one cordic run in flight: vector, angle, plus the pass-through special case
  typedef struct packed {
    logic          vld;
    dp_t           x;
    dp_t           y;
    acc_t          acc;
    logic          zero_xy;
    logic          z_pos;
    logic [InW-1:0] z;
  } stg_t;

  function automatic acc_t angle_of(input logic [4:0] i);
    acc_t a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21344480;
      5'd6:  a = 32'd10671853;
      5'd7:  a = 32'd5335938;
      5'd8:  a = 32'd2667972;
      5'd9:  a = 32'd1333986;
      5'd10: a = 32'd666993;
      5'd11: a = 32'd333496;
      5'd12: a = 32'd166748;
      5'd13: a = 32'd83374;
      5'd14: a = 32'd41687;
      5'd15: a = 32'd20843;
      5'd16: a = 32'd10421;
      5'd17: a = 32'd5210;
      5'd18: a = 32'd2605;
      5'd19: a = 32'd1302;
      5'd20: a = 32'd651;
      5'd21: a = 32'd325;
      5'd22: a = 32'd162;
      5'd23: a = 32'd81;
      5'd24: a = 32'd40;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd2;
      5'd29: a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/v2py_if.sv
// v2py_in_if / v2py_out_if: valid-ready channels of vector_to_pitch_yaw
// depends on v2py_pkg for field widths
interface v2py_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [v2py_pkg::InW-1:0] vec_x;
  logic signed [v2py_pkg::InW-1:0] vec_y;
  logic signed [v2py_pkg::InW-1:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface v2py_out_if;
  logic                       valid;
  logic                       ready;
  logic [v2py_pkg::OutW-1:0]  pitch_deg;
  logic [v2py_pkg::OutW-1:0]  yaw_deg;
  modport source (output valid, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, pitch_deg, yaw_deg, output ready);
endinterface

### rtl/core/v2py_stage.sv
// v2py_stage: one registered cordic vectoring iteration with stall hold
// depends on v2py_pkg
module v2py_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  v2py_pkg::stg_t d,
  output v2py_pkg::stg_t q
);

  v2py_pkg::stg_t q_r, q_nxt;
  v2py_pkg::dp_t  dx, dy;
  v2py_pkg::acc_t ang;

  always_comb begin
    dx = d.y >>> STEP;
    dy = d.x >>> STEP;
    ang = v2py_pkg::angle_of(5'(STEP));
    q_nxt = d;
    if (!d.y[v2py_pkg::DpW-1]) begin
      q_nxt.x   = d.x + dx;
      q_nxt.y   = d.y - dy;
      q_nxt.acc = d.acc + ang;
    end else begin
      q_nxt.x   = d.x - dx;
      q_nxt.y   = d.y + dy;
      q_nxt.acc = d.acc - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= d.vld;
    end
    if (en) begin
      q_r.x       <= q_nxt.x;
      q_r.y       <= q_nxt.y;
      q_r.acc     <= q_nxt.acc;
      q_r.zero_xy <= q_nxt.zero_xy;
      q_r.z_pos   <= q_nxt.z_pos;
      q_r.z       <= q_nxt.z;
    end
  end

  assign q = q_r;

endmodule

### rtl/core/vector_to_pitch_yaw.sv
// vector_to_pitch_yaw: throughput one vector per cycle while the output is not stalled;
// an input register, one stage per yaw cordic iteration, a two-stage gain multiply,
// one stage per pitch cordic iteration and two degree-conversion stages
// the whole pipe advances whenever the output register is empty or taken
// synchronous active-low reset clears every valid bit; payload is not reset
// depends on v2py_pkg, v2py_if and v2py_stage
module vector_to_pitch_yaw #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input logic        clk,
  input logic        rst_n,
  v2py_in_if.sink    in_ch,
  v2py_out_if.source out_ch
);

  localparam int unsigned N = CORDIC_STEPS;

  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // input stage: scale, fold left half-plane
  v2py_pkg::stg_t s_in, s0_r;
  v2py_pkg::dp_t  xi, yi;
  always_comb begin
    xi = v2py_pkg::dp_t'(in_ch.vec_x) <<< v2py_pkg::GuardW;
    yi = v2py_pkg::dp_t'(in_ch.vec_y) <<< v2py_pkg::GuardW;
    s_in.vld     = in_ch.valid;
    s_in.zero_xy = (in_ch.vec_x == '0) && (in_ch.vec_y == '0);
    s_in.z_pos   = !in_ch.vec_z[v2py_pkg::InW-1] && (in_ch.vec_z != '0);
    s_in.z       = in_ch.vec_z;
    if (in_ch.vec_x[v2py_pkg::InW-1]) begin
      s_in.x   = -xi;
      s_in.y   = -yi;
      s_in.acc = 32'h8000_0000;
    end else begin
      s_in.x   = xi;
      s_in.y   = yi;
      s_in.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else if (en) begin
      s0_r.vld <= s_in.vld;
    end
    if (en) begin
      s0_r.x <= s_in.x; s0_r.y <= s_in.y; s0_r.acc <= s_in.acc;
      s0_r.zero_xy <= s_in.zero_xy; s0_r.z_pos <= s_in.z_pos; s0_r.z <= s_in.z;
    end
  end

  v2py_pkg::stg_t ys [N+1];
  assign ys[0] = s0_r;
  for (genvar g = 0; g < N; g++) begin : g_yaw
    v2py_stage #(.STEP(g)) u_st (.clk(clk), .rst_n(rst_n), .en(en), .d(ys[g]), .q(ys[g+1]));
  end

  // gain stage: multiply z by K, keep yaw angle in the payload
  logic                 g1_vld_r, g2_vld_r;
  v2py_pkg::dp_t        g1_x_r, g2_x_r;
  v2py_pkg::acc_t       g1_yaw_r, g2_yaw_r;
  logic                 g1_zxy_r, g1_zp_r, g2_zxy_r, g2_zp_r;
  logic signed [63:0]   g1_prod_r;
  v2py_pkg::dp_t        g2_zk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
    end else if (en) begin
      g1_vld_r <= ys[N].vld;
      g2_vld_r <= g1_vld_r;
    end
    if (en) begin
      g1_prod_r <= 64'(signed'(ys[N].z)) * 64'(v2py_pkg::GainQ30);
      g1_x_r    <= ys[N].x;
      g1_yaw_r  <= ys[N].acc;
      g1_zxy_r  <= ys[N].zero_xy;
      g1_zp_r   <= ys[N].z_pos;
      g2_zk_r   <= g1_prod_r >>> 6;
      g2_x_r    <= g1_x_r;
      g2_yaw_r  <= g1_yaw_r;
      g2_zxy_r  <= g1_zxy_r;
      g2_zp_r   <= g1_zp_r;
    end
  end

  // pitch run: yaw angle rides in the z slot
  v2py_pkg::stg_t p_in;
  v2py_pkg::stg_t ps [N+1];
  always_comb begin
    p_in.vld     = g2_vld_r;
    p_in.x       = g2_x_r;
    p_in.y       = g2_zk_r;
    p_in.acc     = '0;
    p_in.zero_xy = g2_zxy_r;
    p_in.z_pos   = g2_zp_r;
    p_in.z       = g2_yaw_r;
  end
  assign ps[0] = p_in;
  for (genvar g = 0; g < N; g++) begin : g_pitch
    v2py_stage #(.STEP(g)) u_st (.clk(clk), .rst_n(rst_n), .en(en), .d(ps[g]), .q(ps[g+1]));
  end

  // degree conversion: multiply, then round and wrap
  logic            d1_vld_r;
  logic [40:0]     d1_p_r, d1_y_r;
  logic            d1_zxy_r, d1_zp_r;
  logic [40:0]     dp_p, dp_y;
  logic [v2py_pkg::OutW-1:0] pitch_nxt, yaw_nxt;
  logic [v2py_pkg::OutW-1:0] out_p_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
    end else if (en) begin
      d1_vld_r <= ps[N].vld;
    end
    if (en) begin
      d1_p_r   <= 41'(ps[N].acc) * 41'd360 + 41'd32768;
      d1_y_r   <= 41'(ps[N].z) * 41'd360 + 41'd32768;
      d1_zxy_r <= ps[N].zero_xy;
      d1_zp_r  <= ps[N].z_pos;
    end
  end

  always_comb begin
    dp_p = d1_p_r >> 16;
    dp_y = d1_y_r >> 16;
    pitch_nxt = (dp_p >= 41'(v2py_pkg::Deg360Q16)) ? '0 : dp_p[v2py_pkg::OutW-1:0];
    yaw_nxt   = (dp_y >= 41'(v2py_pkg::Deg360Q16)) ? '0 : dp_y[v2py_pkg::OutW-1:0];
    if (d1_zxy_r) begin
      pitch_nxt = d1_zp_r ? v2py_pkg::Deg90Q16 : v2py_pkg::Deg270Q16;
      yaw_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d1_vld_r;
    end
    if (en) begin
      out_p_r <= pitch_nxt;
      out_y_r <= yaw_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.pitch_deg = out_p_r;
  assign out_ch.yaw_deg   = out_y_r;

endmodule

### sim/tb_top.sv
// tb_top: regression bench for vector_to_pitch_yaw, directed vectors then random traffic
// depends on v2py_pkg, v2py_in_if / v2py_out_if and the vector_to_pitch_yaw rtl
module tb_top;

  localparam int unsigned Steps      = 24;
  localparam int unsigned Latency    = 2 * Steps + 5;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned LongHold   = 400;

  typedef struct {
    logic [v2py_pkg::OutW-1:0] pitch;
    logic [v2py_pkg::OutW-1:0] yaw;
  } angles_t;

  localparam bit [31:0] AtanTurn [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21344480,
    10671853, 5335938, 2667972, 1333986, 666993, 333496, 166748,
    83374, 41687, 20843, 10421, 5210, 2605, 1302, 651, 325, 162,
    81, 40, 20, 10, 5, 2, 1, 0, 0
  };

  logic clk;
  logic rst_n;

  v2py_in_if  in_ch ();
  v2py_out_if out_ch ();

  vector_to_pitch_yaw #(.CORDIC_STEPS(Steps)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  angles_t     pending_angles[$];
  int unsigned err_count;
  int unsigned quiet_cycles;
  bit          send_gaps;
  bit          recv_gaps;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_left;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // vectoring rotation: drives y to zero, returns the updated angle
  function automatic bit [31:0] rotate_to_axis(inout logic signed [63:0] vx,
                                               inout logic signed [63:0] vy,
                                               input bit [31:0] turn);
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    for (int i = 0; i < Steps && i < 32; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx = vx + dx;
        vy = vy - dy;
        turn = turn + AtanTurn[i];
      end else begin
        vx = vx - dx;
        vy = vy + dy;
        turn = turn - AtanTurn[i];
      end
    end
    return turn;
  endfunction

  function automatic logic [v2py_pkg::OutW-1:0] turn_to_deg(input bit [31:0] turn);
    logic [63:0] d;
    d = ({32'd0, turn} * 64'd360 + 64'd32768) >> 16;
    if (d >= 64'(v2py_pkg::Deg360Q16)) d = '0;
    return d[v2py_pkg::OutW-1:0];
  endfunction

  function automatic angles_t predict_angles(input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z);
    angles_t a;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] vz;
    bit [31:0] turn;
    if (x == 0 && y == 0) begin
      a.pitch = (z > 0) ? v2py_pkg::Deg90Q16 : v2py_pkg::Deg270Q16;
      a.yaw = '0;
      return a;
    end
    vx = 64'(x) <<< v2py_pkg::GuardW;
    vy = 64'(y) <<< v2py_pkg::GuardW;
    turn = 32'd0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      turn = 32'h8000_0000;
    end
    turn = rotate_to_axis(vx, vy, turn);
    a.yaw = turn_to_deg(turn);
    vz = 64'(z) * 64'(v2py_pkg::GainQ30);
    vz = vz >>> (30 - v2py_pkg::GuardW);
    turn = rotate_to_axis(vx, vz, 32'd0);
    a.pitch = turn_to_deg(turn);
    return a;
  endfunction

  task automatic send_vec(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic signed [31:0] z);
    int unsigned gap;
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.vec_x = x;
    in_ch.vec_y = y;
    in_ch.vec_z = z;
    do @(posedge clk); while (!in_ch.ready);
    pending_angles.push_back(predict_angles(x, y, z));
  endtask

  task automatic release_input;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_field;
    case ($urandom_range(0, 4))
      0: return $signed($urandom_range(0, 255)) - 128;
      1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    logic signed [31:0] ext [6] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0,
                                    32'sd1, -32'sd1, 32'sh0001_0000};
    // zero x and y: positive, zero and negative z
    send_vec(0, 0, 32'sh0001_0000);
    send_vec(0, 0, 0);
    send_vec(0, 0, -32'sd1);
    send_vec(0, 0, 32'sh8000_0000);
    send_vec(0, 0, 32'sh7fff_ffff);
    // axes and quadrants
    send_vec(32'sh0001_0000, 0, 0);
    send_vec(-32'sh0001_0000, 0, 0);
    send_vec(0, 32'sh0001_0000, 0);
    send_vec(0, -32'sh0001_0000, 0);
    send_vec(-32'sh0001_0000, -32'sd1, 0);
    send_vec(-32'sh0001_0000, 32'sd1, 0);
    send_vec(32'sh0001_0000, -32'sd1, -32'sh0001_0000);
    for (int i = 0; i < 12; i++)
      send_vec(ext[$urandom_range(0, 5)], ext[i % 6], ext[(i + 3) % 6]);
    release_input();
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_vec(rand_field(), rand_field(), rand_field());
    release_input();
  endtask

  task automatic test_backpressure;
    hold_req = 1'b1;
    for (int i = 0; i < 120; i++)
      send_vec($urandom, $urandom, $urandom);
    release_input();
  endtask

  task automatic test_full_rate;
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(150);
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    angles_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $error("result with no request outstanding: pitch %0d yaw %0d",
               out_ch.pitch_deg, out_ch.yaw_deg);
        err_count++;
      end else begin
        want = pending_angles.pop_front();
        if (out_ch.pitch_deg !== want.pitch) begin
          $error("pitch_deg expected %0d got %0d", want.pitch, out_ch.pitch_deg);
          err_count++;
        end
        if (out_ch.yaw_deg !== want.yaw) begin
          $error("yaw_deg expected %0d got %0d", want.yaw, out_ch.yaw_deg);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("vector_to_pitch_yaw regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.vec_z = '0;
    out_ch.ready = 1'b0;
    err_count = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(300);
    test_backpressure();
    test_random(250);
    test_full_rate();

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (err_count == 0)
      $display("vector_to_pitch_yaw regression: pass");
    else
      $display("vector_to_pitch_yaw regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/core/v2py_pkg.sv
rtl/core/v2py_if.sv
rtl/core/v2py_stage.sv
rtl/core/vector_to_pitch_yaw.sv
sim/tb_top.sv
